// ===== sv/hvt_pkg.sv =====
// shared types and constants for the histogram valley threshold block
// used by hvt_hist, hvt_div, the top level and the testbench; depends on nothing

package hvt_pkg;

    localparam int COUNT_W    = 24;               // histogram bin width
    localparam int TOTAL_W    = COUNT_W + 1;      // pixel total width
    localparam int NUM_BINS   = 256;
    localparam int BIN_AW     = 8;
    localparam int SUM_W      = COUNT_W + 8;      // window and prefix sums
    localparam int DVS_W      = 9;                // divisor L+1
    localparam int HALF_W     = 7;                // half window L/2
    localparam int DIST_W     = SUM_W + 3;        // signed balance distance
    localparam int IDX_W      = BIN_AW + 2;       // signed window index
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0]   BIN_MAX   = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;
    localparam logic [BIN_AW-1:0]    BIN_TOP1  = 8'd254;
    localparam logic [BIN_AW-1:0]    BIN_TOP0  = 8'd255;
    localparam logic [BIN_AW-1:0]    X_LAST    = 8'd254;
    localparam logic [BIN_AW-1:0]    EVAL_FIRST = 8'd3;

    localparam logic [CFG_DATA_W-1:0] LEN_RESET  = 8'd8;
    localparam logic [CFG_DATA_W-1:0] VIDX_RESET = 8'd1;

    localparam logic MODE_BALANCED = 1'b0;
    localparam logic MODE_COUNT    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_LEN  = 2'd0,
        CFG_SELECT_MODE = 2'd1,
        CFG_VALLEY_IDX  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] threshold;
        logic       found;
    } t_out_item;

    typedef struct packed {
        logic              rd_en;
        logic [BIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BIN_AW-1:0] wr_addr;
        logic [COUNT_W-1:0] wr_data;
        logic              clr;
    } t_hist_req;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_T_RD0,
        S_T_RD1,
        S_T_ADD,
        S_PF_RD,
        S_PF_ADD,
        S_RD_ADD,
        S_RD_SUB,
        S_RD_MID,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EVAL,
        S_CMP,
        S_EMIT
    } t_state;

endpackage

// ===== sv/hvt_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies

module hvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/hvt_hist.sv =====
// histogram bin store: ram plus one valid bit per bin, bulk clear resets all valid bits together
// depends on hvt_pkg and hvt_ram

module hvt_hist
    import hvt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_hist_req          i_req,
    output logic [COUNT_W-1:0] o_rdata
);

    logic [NUM_BINS-1:0] r_valid;
    logic                r_rd_ok;
    logic [COUNT_W-1:0]  ram_q;

    hvt_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_data),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            // bins never written since the last clear read as zero
            if (i_req.rd_en) begin
                r_rd_ok <= r_valid[i_req.rd_addr];
            end else begin
                r_rd_ok <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rd_ok ? ram_q : '0;

endmodule

// ===== sv/hvt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on hvt_pkg

module hvt_div
    import hvt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [SUM_W-1:0]     r_q;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        trial     = {r_rem, r_q[SUM_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        ge        = (trial >= {1'b0, r_dvs});
        n_rem     = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_q   <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[SUM_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q[COUNT_W-1:0];

endmodule

// ===== sv/histogram_valley_threshold.sv =====
// Histogram valley threshold selection, top level.
// Input channel (i_in_valid, o_in_stall, i_in_data): one 8-bit pixel per
// transfer, with last marking the final pixel of an image. Each pixel is a
// bin read, then a saturating write back through the bin ram, during which
// the input stalls. After the last pixel the block smooths the histogram
// with a sliding window and picks a valley, one bin at a time through a
// shared serial divider; each bin's divide finishes before the next bin
// starts. The input channel stalls for the whole analysis.
// Output channel (o_out_valid, i_out_stall, o_out_data): one transfer per
// image carrying threshold and found, held in an output register. If the
// receiver stalls with an earlier result still held, the block waits before
// loading the new one; the histogram is cleared in the cycle of the load.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data) writes smoothing length,
// select mode and valley index; write only while the block is idle.
// Synchronous reset (i_rst_n low) empties the histogram, drops any result
// and restores the default config: length 8, balanced mode, valley 1.

module histogram_valley_threshold
    import hvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_len;
    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_vidx;

    logic [BIN_AW-1:0]  r_pix;
    logic               r_last;
    logic [TOTAL_W-1:0] r_total;

    logic [TOTAL_W-1:0] r_t;
    logic [DIST_W-1:0]  r_n2t;
    logic [HALF_W-1:0]  r_k;
    logic [BIN_AW-1:0]  r_x;
    logic [SUM_W-1:0]   r_w;
    logic [SUM_W-1:0]   r_pref;
    logic [SUM_W-1:0]   r_pref_prev;
    logic [COUNT_W-1:0] r_s0, r_s1, r_s2;
    logic               r_valley;
    logic [DIST_W-1:0]  r_dist;
    logic [DIST_W-1:0]  r_best;
    logic [7:0]         r_left;
    logic [7:0]         r_thr;
    logic               r_found;

    logic      r_out_valid;
    t_out_item r_out_data;

    t_hist_req          hist_req;
    logic [COUNT_W-1:0] hist_rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               in_accept;
    logic               out_free;
    logic [HALF_W-1:0]  half;
    logic [IDX_W-1:0]   add_idx;
    logic [IDX_W-1:0]   sub_idx;
    logic               add_ok;
    logic               sub_ok;
    logic [TOTAL_W-1:0] t_sum;
    logic [DIST_W-1:0]  diff;
    logic [COUNT_W-1:0] bin_inc;

    hvt_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hist_req),
        .o_rdata (hist_rdata)
    );

    hvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        half    = r_len[CFG_DATA_W-1:1];
        add_idx = {2'b00, r_x} + {3'b000, half};
        sub_idx = {2'b00, r_x} - {3'b000, half} - IDX_W'(1);
        add_ok  = (add_idx[IDX_W-1:BIN_AW] == '0);
        sub_ok  = !sub_idx[IDX_W-1];
        t_sum   = r_t + TOTAL_W'(hist_rdata);
        diff    = r_n2t - {2'b00, r_pref_prev, 1'b0};
        bin_inc = (hist_rdata == BIN_MAX) ? hist_rdata : hist_rdata + COUNT_W'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_accept) n_state = S_INC;
            S_INC:      n_state = r_last ? S_T_RD0 : S_IDLE;
            S_T_RD0:    n_state = S_T_RD1;
            S_T_RD1:    n_state = S_T_ADD;
            S_T_ADD:    n_state = (half == '0) ? S_RD_ADD : S_PF_RD;
            S_PF_RD:    n_state = S_PF_ADD;
            S_PF_ADD:   n_state = (r_k + HALF_W'(1) == half) ? S_RD_ADD : S_PF_RD;
            S_RD_ADD:   n_state = S_RD_SUB;
            S_RD_SUB:   n_state = S_RD_MID;
            S_RD_MID:   n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_x >= EVAL_FIRST) ? S_EVAL : S_RD_ADD;
                end
            end
            S_EVAL:     n_state = S_CMP;
            S_CMP:      n_state = (r_x == X_LAST) ? S_EMIT : S_RD_ADD;
            S_EMIT:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ram and divider controls
    always_comb begin
        hist_req         = '0;
        div_req.start    = 1'b0;
        div_req.dividend = r_w;
        div_req.divisor  = {1'b0, r_len} + DVS_W'(1);
        unique case (r_state)
            S_IDLE: begin
                hist_req.rd_en   = in_accept;
                hist_req.rd_addr = i_in_data.pixel;
            end
            S_INC: begin
                hist_req.wr_en   = 1'b1;
                hist_req.wr_addr = r_pix;
                hist_req.wr_data = bin_inc;
            end
            S_T_RD0: begin
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = BIN_TOP1;
            end
            S_T_RD1: begin
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = BIN_TOP0;
            end
            S_PF_RD: begin
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = {1'b0, r_k};
            end
            S_RD_ADD: begin
                hist_req.rd_en   = add_ok;
                hist_req.rd_addr = add_idx[BIN_AW-1:0];
            end
            S_RD_SUB: begin
                hist_req.rd_en   = sub_ok;
                hist_req.rd_addr = sub_idx[BIN_AW-1:0];
            end
            S_RD_MID: begin
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = r_x;
            end
            S_DIV_GO: div_req.start = 1'b1;
            S_EMIT:   hist_req.clr = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_RESET;
            r_mode      <= MODE_BALANCED;
            r_vidx      <= VIDX_RESET;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SMOOTH_LEN:  r_len  <= i_cfg_data;
                    CFG_SELECT_MODE: r_mode <= i_cfg_data[0];
                    CFG_VALLEY_IDX:  r_vidx <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept && r_total != TOTAL_MAX) begin
                r_total <= r_total + TOTAL_W'(1);
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_total     <= '0;
            end
        end
    end

    // analysis datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix  <= i_in_data.pixel;
            r_last <= i_in_data.last;
        end
        unique case (r_state)
            S_T_RD0: begin
                r_x       <= '0;
                r_k       <= '0;
                r_w       <= '0;
                r_pref    <= '0;
                r_best    <= DIST_W'(r_total);
                r_left    <= r_vidx;
                r_thr     <= '0;
                r_found   <= 1'b0;
            end
            S_T_RD1:  r_t <= TOTAL_W'(hist_rdata);
            // n + 2*(h254 + h255), so the distance is this minus twice the prefix
            S_T_ADD:  r_n2t <= DIST_W'(r_total) + DIST_W'({t_sum, 1'b0});
            S_PF_ADD: begin
                r_w <= r_w + SUM_W'(hist_rdata);
                r_k <= r_k + HALF_W'(1);
            end
            S_RD_SUB: r_w <= r_w + SUM_W'(hist_rdata);
            S_RD_MID: r_w <= r_w - SUM_W'(hist_rdata);
            S_DIV_GO: begin
                r_pref_prev <= r_pref;
                r_pref      <= r_pref + SUM_W'(hist_rdata);
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_s0 <= r_s1;
                    r_s1 <= r_s2;
                    r_s2 <= div_rsp.quot;
                    if (r_x < EVAL_FIRST) begin
                        r_x <= r_x + 1'b1;
                    end
                end
            end
            S_EVAL: begin
                r_valley <= (r_s0 >= r_s1) && (r_s1 < r_s2);
                r_dist   <= diff[DIST_W-1] ? (~diff + DIST_W'(1)) : diff;
            end
            S_CMP: begin
                // the candidate bin is one behind the newest smoothed bin
                if (r_valley) begin
                    if (r_mode == MODE_BALANCED) begin
                        if (r_dist < r_best) begin
                            r_best  <= r_dist;
                            r_thr   <= r_x - 1'b1;
                            r_found <= 1'b1;
                        end
                    end else if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                        if (r_left == 8'd1) begin
                            r_thr   <= r_x - 1'b1;
                            r_found <= 1'b1;
                        end
                    end
                end
                r_x <= r_x + 1'b1;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_data.threshold <= r_thr;
                    r_out_data.found     <= r_found;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for histogram_valley_threshold: streams images pixel by pixel,
// predicts each image's threshold from its own histogram copy or the directed row and checks every result
// depends on hvt_pkg and the block's rtl only

module tb_top;
    import hvt_pkg::*;

    localparam int CYCLE_LIMIT   = 12_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_CFG, ROW_PIXEL} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_cfg_idx   reg_idx;
        logic [7:0] value;      // register data or pixel
        logic       last;
        logic       typed;      // result written into the row
        logic [7:0] exp_thr;
        logic       exp_found;
    } t_stim_row;

    localparam int NUM_ROWS = 31;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        // reset config: lone pixels never survive the divide by 9
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd0,   1'b1, 1'b1, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd255, 1'b1, 1'b1, 8'd0, 1'b0},
        '{ROW_CFG,   CFG_SMOOTH_LEN,  8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG,   CFG_SELECT_MODE, 8'(MODE_COUNT), 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG,   CFG_VALLEY_IDX,  8'd1,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd10,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd10,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd12,  1'b1, 1'b0, 8'd0, 1'b0},
        // valley index zero selects nothing
        '{ROW_CFG,   CFG_VALLEY_IDX,  8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd100, 1'b1, 1'b1, 8'd0, 1'b0},
        // fewer valleys than asked for
        '{ROW_CFG,   CFG_VALLEY_IDX,  8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd50,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd60,  1'b1, 1'b1, 8'd0, 1'b0},
        // balanced split with the edge bins in the starting count
        '{ROW_CFG,   CFG_SELECT_MODE, 8'(MODE_BALANCED), 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd0,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd1,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd254, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd3,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd3,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd200, 1'b1, 1'b0, 8'd0, 1'b0},
        // widest window, divisor 256 flattens everything
        '{ROW_CFG,   CFG_SMOOTH_LEN,  8'd255, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd128, 1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd7,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd250, 1'b1, 1'b1, 8'd0, 1'b0},
        '{ROW_CFG,   CFG_SMOOTH_LEN,  8'd1,   1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd20,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd20,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd21,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd40,  1'b0, 1'b0, 8'd0, 1'b0},
        '{ROW_PIXEL, CFG_SMOOTH_LEN,  8'd40,  1'b1, 1'b0, 8'd0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    // predictor state
    logic [COUNT_W-1:0] bin_count [NUM_BINS] = '{default: '0};
    logic [TOTAL_W-1:0] pixels_seen = '0;
    logic [7:0]         cur_len  = LEN_RESET;
    logic               cur_mode = MODE_BALANCED;
    logic [7:0]         cur_vidx = VIDX_RESET;

    t_out_item pending_results [$];
    logic      row_typed = 1'b0;
    t_out_item row_result = '0;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int mismatch_cnt   = 0;
    int pixels_sent    = 0;
    int images_sent    = 0;
    int results_checked = 0;
    int unsigned cycles_run = 0;

    histogram_valley_threshold u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // smooth the histogram copy and pick the valley for the current settings
    function automatic t_out_item choose_threshold();
        longint smooth [NUM_BINS];
        bit     valley [NUM_BINS];
        longint acc, running, split_gap, best;
        int     half, lo, hi, left;
        t_out_item pick;
        pick = '0;
        half = int'(cur_len) / 2;
        for (int x = 0; x < NUM_BINS; x++) begin
            lo  = (x - half < 0) ? 0 : x - half;
            hi  = (x + half > NUM_BINS - 1) ? NUM_BINS - 1 : x + half;
            acc = 0;
            for (int k = lo; k <= hi; k++)
                acc += longint'(bin_count[k]);
            smooth[x] = acc / (longint'(cur_len) + 1);
        end
        for (int x = 2; x < NUM_BINS - 2; x++)
            valley[x] = smooth[x-1] >= smooth[x] && smooth[x] < smooth[x+1];
        if (cur_mode == MODE_BALANCED) begin
            running = longint'(bin_count[0]) + longint'(bin_count[1])
                    - longint'(bin_count[254]) - longint'(bin_count[255]);
            best = longint'(pixels_seen);
            for (int x = 2; x < NUM_BINS - 2; x++) begin
                running += longint'(bin_count[x]);
                if (valley[x]) begin
                    split_gap = longint'(pixels_seen) - 2 * running;
                    if (split_gap < 0)
                        split_gap = -split_gap;
                    // strict compare keeps the first of equal splits
                    if (split_gap < best) begin
                        best = split_gap;
                        pick.threshold = 8'(x);
                        pick.found = 1'b1;
                    end
                end
            end
        end else begin
            left = int'(cur_vidx);
            for (int x = 2; x < NUM_BINS - 2 && left != 0; x++) begin
                if (valley[x]) begin
                    left--;
                    if (left == 0) begin
                        pick.threshold = 8'(x);
                        pick.found = 1'b1;
                    end
                end
            end
        end
        return pick;
    endfunction

    // pixel transfers feed the predictor, result transfers are checked
    always @(posedge i_clk) begin : monitor
        t_out_item predicted;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pixels_sent++;
                if (bin_count[i_in_data.pixel] != BIN_MAX)
                    bin_count[i_in_data.pixel] = bin_count[i_in_data.pixel] + 1'b1;
                if (pixels_seen != TOTAL_MAX)
                    pixels_seen = pixels_seen + 1'b1;
                if (i_in_data.last) begin
                    predicted = choose_threshold();
                    pending_results.push_back(row_typed ? row_result : predicted);
                    images_sent++;
                    foreach (bin_count[i])
                        bin_count[i] = '0;
                    pixels_seen = '0;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected result: threshold=%0d found=%0b",
                                 o_out_data.threshold, o_out_data.found);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.threshold !== want.threshold ||
                        o_out_data.found !== want.found) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"result %0d: expected threshold=%0d found=%0b, ",
                                      "got threshold=%0d found=%0b"},
                                     results_checked, want.threshold, want.found,
                                     o_out_data.threshold, o_out_data.found);
                    end
                    results_checked++;
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    initial begin : watchdog
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] pix, input logic last_pix,
                              input logic typed, input t_out_item want);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= '{pixel: pix, last: last_pix};
        row_typed  <= typed;
        row_result <= want;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // hold off the pixel stream until every pending threshold has come out
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SMOOTH_LEN:  cur_len  = val;
            CFG_SELECT_MODE: cur_mode = val[0];
            CFG_VALLEY_IDX:  cur_vidx = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int         len, sel, phase_pixels, phase_images;
        int         centers [3];
        logic [7:0] pix, len_val, vidx_val;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct   <= 8;
        recv_stall_pct <= 66;

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
            end else begin
                send_pixel(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed,
                           '{threshold: DIRECTED[i].exp_thr, found: DIRECTED[i].exp_found});
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   <= (phase == 0) ? 8 : (phase == 1) ? 66 : 0;
            recv_stall_pct <= (phase == 0) ? 66 : (phase == 1) ? 8 : 0;
            phase_pixels = 0;
            phase_images = 0;
            while (phase_pixels < 135 || phase_images < 10) begin
                if (phase_images == 0 || $urandom_range(2) == 0) begin
                    sel = $urandom_range(9);
                    // short windows keep small images from smoothing to nothing
                    len_val = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 :
                              (sel == 2) ? 8'd254 : (sel == 3) ? 8'd1 :
                              (sel < 8) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
                    sel = $urandom_range(7);
                    vidx_val = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 :
                               (sel == 2) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 4));
                    wait_idle();
                    write_reg(CFG_SMOOTH_LEN, len_val);
                    write_reg(CFG_SELECT_MODE, 8'($urandom_range(1)));
                    write_reg(CFG_VALLEY_IDX, vidx_val);
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 16);
                foreach (centers[c])
                    centers[c] = $urandom_range(255);
                for (int p = 0; p < len; p++) begin
                    sel = $urandom_range(5);
                    if (sel == 0)
                        pix = 8'($urandom_range(255));
                    else
                        pix = 8'(centers[sel % 3] + int'($urandom_range(6)) - 3);
                    send_pixel(pix, p == len - 1, 1'b0, '0);
                end
                phase_pixels += len;
                phase_images++;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("ran %0d pixels in %0d images over three idling phases", pixels_sent,
                 images_sent);
        $display("checked %0d thresholds, %0d mismatches", results_checked, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hvt_pkg.sv
sv/hvt_ram.sv
sv/hvt_hist.sv
sv/hvt_div.sv
sv/histogram_valley_threshold.sv
tb/tb_top.sv
